// File: rtl/core/hjd_pkg.sv
// Package for the height jump detector: field widths, register indexes,
// reset values and the default delay length. No dependencies.
package hjd_pkg;

    localparam int HJD_DELAY_LEN = 5;

    localparam int HEIGHT_W = 11;
    localparam int STAMP_W  = 32;
    localparam int TOTAL_W  = 16;
    localparam int THR_W    = 11;
    localparam int HIST_W   = 3;

    localparam int S_DATA_W = 48;
    localparam int M_DATA_W = 64;

    typedef logic [HEIGHT_W-1:0] height_t;
    typedef logic [STAMP_W-1:0]  stamp_t;
    typedef logic [TOTAL_W-1:0]  total_t;
    typedef logic [THR_W-1:0]    thr_t;
    typedef logic [HIST_W-1:0]   hist_t;
    typedef logic [0:0]          reg_idx_t;

    localparam reg_idx_t REG_RISE_THR = 1'b0;
    localparam reg_idx_t REG_FALL_THR = 1'b1;

    localparam thr_t RISE_THR_RESET = 11'd35;
    localparam thr_t FALL_THR_RESET = 11'd18;

    localparam hist_t  HIST_FULL = 3'b111;
    localparam total_t TOTAL_MAX = 16'hFFFF;

endpackage

// File: rtl/core/height_jump_detector.sv
// Top level of the height jump detector: stream in/out, threshold registers,
// rise/fall history tracking. Uses hjd_pkg and hjd_delay_line.
//
// Usage:
//   s_* channel takes one word per sample: height and time stamp.
//   m_* channel gives exactly one result word per sample: jump flag,
//   airborne flag, saturating jump total, and the stamp/height of the
//   sample that confirmed a jump (zero otherwise).
//   cfg_we/cfg_index/cfg_data write rise_threshold (index 0) and
//   fall_threshold (index 1); write only while no sample is in flight.
// Timing:
//   m_tvalid rises in the cycle after input accept. With m_tready high, one
//   sample per cycle is sustained; the only stage is the result register,
//   and the state update is a short compare and shift on the accepted word.
// Reset:
//   Thresholds return to 35 and 18, history, airborne, total and the delay
//   line fill count clear. The first DELAY_LEN samples only fill the line.
// Stall:
//   While m_tready is low and a result waits, s_tready drops; a new sample
//   is taken in the same cycle the waiting result is taken.
module height_jump_detector #(
    parameter int DELAY_LEN = hjd_pkg::HJD_DELAY_LEN
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // s_tdata: height[10:0], time_stamp[42:11], zero fill [47:43]
    input  logic [hjd_pkg::S_DATA_W-1:0]  s_tdata,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // m_tdata: jump_found[0], airborne[1], jump_total[17:2],
    //          jump_time[49:18], jump_height[60:50], zero fill [63:61]
    output logic [hjd_pkg::M_DATA_W-1:0]  m_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic                          cfg_we,
    input  hjd_pkg::reg_idx_t             cfg_index,
    input  hjd_pkg::thr_t                 cfg_data
);
    import hjd_pkg::*;

    thr_t    rise_thr_reg;
    thr_t    fall_thr_reg;
    hist_t   rise_hist_reg,  rise_hist_next;
    hist_t   fall_hist_reg,  fall_hist_next;
    logic    in_jump_reg,    in_jump_next;
    total_t  jump_cnt_reg,   jump_cnt_next;
    logic    m_valid_reg;
    logic    found_reg;
    logic    found_next;
    logic    air_reg;
    total_t  total_reg;
    stamp_t  jtime_reg;
    height_t jheight_reg;

    height_t in_height;
    stamp_t  in_stamp;
    height_t old_height;
    logic    filled;
    logic    s_fire;
    logic    rise_bit;
    logic    fall_bit;
    hist_t   rise_shift;
    hist_t   fall_shift;

    assign in_height = s_tdata[HEIGHT_W-1:0];
    assign in_stamp  = s_tdata[HEIGHT_W+STAMP_W-1:HEIGHT_W];

    assign s_tready = !m_valid_reg || m_tready;
    assign s_fire   = s_tvalid && s_tready;

    hjd_delay_line #(
        .DELAY_LEN (DELAY_LEN)
    ) u_delay (
        .clk      (clk),
        .rst_n    (rst_n),
        .shift_en (s_fire),
        .din      (in_height),
        .oldest   (old_height),
        .filled   (filled)
    );

    // drop: h - old < -rise  <=>  h + rise < old
    assign rise_bit = ({1'b0, in_height} + {1'b0, rise_thr_reg}) < {1'b0, old_height};
    // climb back: h - old > fall  <=>  h > old + fall
    assign fall_bit = {1'b0, in_height} > ({1'b0, old_height} + {1'b0, fall_thr_reg});

    assign rise_shift = {rise_hist_reg[HIST_W-2:0], rise_bit};
    assign fall_shift = {fall_hist_reg[HIST_W-2:0], fall_bit};

    always_comb
    begin
        rise_hist_next = rise_hist_reg;
        fall_hist_next = fall_hist_reg;
        in_jump_next   = in_jump_reg;
        jump_cnt_next  = jump_cnt_reg;
        found_next     = 1'b0;
        if (filled)
        begin
            if (!in_jump_reg)
            begin
                rise_hist_next = rise_shift;
                if (rise_shift == HIST_FULL)
                begin
                    found_next     = 1'b1;
                    in_jump_next   = 1'b1;
                    rise_hist_next = '0;
                    if (jump_cnt_reg != TOTAL_MAX)
                    begin
                        jump_cnt_next = jump_cnt_reg + TOTAL_W'(1);
                    end
                end
            end
            else
            begin
                fall_hist_next = fall_shift;
                if (fall_shift == HIST_FULL)
                begin
                    in_jump_next   = 1'b0;
                    fall_hist_next = '0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rise_thr_reg  <= RISE_THR_RESET;
            fall_thr_reg  <= FALL_THR_RESET;
            rise_hist_reg <= '0;
            fall_hist_reg <= '0;
            in_jump_reg   <= 1'b0;
            jump_cnt_reg  <= '0;
            m_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_RISE_THR: rise_thr_reg <= cfg_data;
                    REG_FALL_THR: fall_thr_reg <= cfg_data;
                    default:      ;
                endcase
            end
            if (s_fire)
            begin
                rise_hist_reg <= rise_hist_next;
                fall_hist_reg <= fall_hist_next;
                in_jump_reg   <= in_jump_next;
                jump_cnt_reg  <= jump_cnt_next;
            end
            if (s_fire)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // result word payload
    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            found_reg   <= found_next;
            air_reg     <= in_jump_next;
            total_reg   <= jump_cnt_next;
            jtime_reg   <= found_next ? in_stamp : '0;
            jheight_reg <= found_next ? in_height : '0;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {3'b000, jheight_reg, jtime_reg, total_reg, air_reg, found_reg};

endmodule

// File: rtl/core/hjd_delay_line.sv
// Delay line for height samples: shift line of DELAY_LEN taps plus a fill
// counter that marks when the oldest tap holds a real sample. Uses hjd_pkg.
module hjd_delay_line #(
    parameter int DELAY_LEN = hjd_pkg::HJD_DELAY_LEN
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            shift_en,
    input  hjd_pkg::height_t din,
    output hjd_pkg::height_t oldest,
    output logic            filled
);
    import hjd_pkg::*;

    localparam int CNT_W = $clog2(DELAY_LEN + 1);

    height_t           tap_reg [DELAY_LEN];
    logic [CNT_W-1:0]  fill_cnt_reg;
    logic [CNT_W-1:0]  fill_cnt_next;

    assign filled = (fill_cnt_reg == CNT_W'(DELAY_LEN));
    assign oldest = tap_reg[DELAY_LEN-1];

    always_comb
    begin
        fill_cnt_next = fill_cnt_reg;
        if (shift_en && !filled)
        begin
            fill_cnt_next = fill_cnt_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_cnt_reg <= '0;
        end
        else
        begin
            fill_cnt_reg <= fill_cnt_next;
        end
    end

    // taps hold no reset; the fill counter covers unwritten entries
    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            tap_reg[0] <= din;
            for (int i = 1; i < DELAY_LEN; i++)
            begin
                tap_reg[i] <= tap_reg[i-1];
            end
        end
    end

endmodule
